/* rtl/core/ncad_pkg.sv */
// Package for the notification attribute deframer.
// Holds the parse phase type, item and result structs, and header constants.
// No dependencies.
package ncad_pkg;

    localparam int unsigned HDR_LEN_INT = 5;
    localparam logic [2:0]  HDR_LEN     = 3'(HDR_LEN_INT);
    localparam logic [7:0]  ATTR_INVALID = 8'hff;
    localparam logic [7:0]  CMD_NEW_HDR  = 8'h00;

    typedef enum logic [2:0] {
        PH_HDR    = 3'd0,
        PH_ATTRID = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_fragment;
        logic       last_of_fragment;
    } in_item_t;

    typedef struct packed {
        logic        last_of_attribute;
        logic        empty_attribute;
        logic [15:0] byte_index;
        logic [7:0]  attr_byte;
        logic [7:0]  attribute_id;
        logic [31:0] notif_uuid;
    } res_t;

endpackage

/* rtl/core/ncad_in_stage.sv */
// Input register for received bytes of the data source stream.
// Depends on ncad_pkg for the item struct.
module ncad_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ncad_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output ncad_pkg::in_item_t item
);
    import ncad_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new request when empty or whenever the held one moves on this cycle.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/ncad_parser.sv */
// Byte parser: header capture, attribute id and length, data byte emission.
// Depends on ncad_pkg for phase type, structs and constants.
module ncad_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               armed,
    input  logic               fire,
    input  ncad_pkg::in_item_t item,
    output logic               res_valid,
    output ncad_pkg::res_t     res
);
    import ncad_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  hpos_reg,   hpos_next;
    logic [31:0] uuid_reg,   uuid_next;
    logic [7:0]  attr_reg,   attr_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] dpos_reg,   dpos_next;

    phase_t      ph;
    logic [2:0]  hp;
    logic [2:0]  hp_inc;
    logic [1:0]  lane;
    logic [15:0] len;
    logic        final_byte;

    always_comb begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        uuid_next   = uuid_reg;
        attr_next   = attr_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        dpos_next   = dpos_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.notif_uuid   = uuid_reg;
        res.attribute_id = attr_reg;

        ph = phase_reg;
        hp = hpos_reg;
        unique case (phase_reg)
            PH_HDR, PH_ATTRID, PH_LEN_LO, PH_LEN_HI, PH_DATA: ph = phase_reg;
            default: ph = PH_HDR;
        endcase
        // Fragment start restarts the header; command 0 opens a new response.
        if (item.first_of_fragment &&
            ((ph == PH_HDR) || (ph == PH_ATTRID && item.data_byte == CMD_NEW_HDR))) begin
            ph = PH_HDR;
            hp = 3'd0;
        end
        hp_inc     = hp + 3'd1;
        lane       = 2'(hp - 3'd1);
        len        = {item.data_byte, len_lo_reg};
        final_byte = (remain_reg <= 16'd1);

        if (fire && armed) begin
            unique case (ph)
                PH_ATTRID: begin
                    attr_next  = item.data_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_lo_next = item.data_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_lo_next = 8'd0;
                    dpos_next   = 16'd0;
                    if (len == 16'd0) begin
                        res_valid             = 1'b1;
                        res.empty_attribute   = 1'b1;
                        res.last_of_attribute = 1'b1;
                        remain_next = 16'd0;
                        attr_next   = ATTR_INVALID;
                        phase_next  = PH_ATTRID;
                    end else begin
                        remain_next = len;
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    res_valid             = 1'b1;
                    res.attr_byte         = item.data_byte;
                    res.byte_index        = dpos_reg;
                    res.last_of_attribute = final_byte;
                    dpos_next = dpos_reg + 16'd1;
                    if (final_byte) begin
                        remain_next = 16'd0;
                        attr_next   = ATTR_INVALID;
                        phase_next  = PH_ATTRID;
                    end else begin
                        remain_next = remain_reg - 16'd1;
                    end
                end
                default: begin
                    // Header: byte 0 is the command, bytes 1..4 the UUID.
                    if (hp == 3'd0) begin
                        uuid_next = 32'd0;
                    end else if (hp < HDR_LEN) begin
                        uuid_next[8*lane +: 8] = uuid_reg[8*lane +: 8] | item.data_byte;
                    end
                    hpos_next  = hp_inc;
                    phase_next = PH_HDR;
                    if (hp_inc >= HDR_LEN || item.last_of_fragment) begin
                        hpos_next  = 3'd0;
                        phase_next = PH_ATTRID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            hpos_reg   <= 3'd0;
            uuid_reg   <= 32'd0;
            attr_reg   <= ATTR_INVALID;
            len_lo_reg <= 8'd0;
            remain_reg <= 16'd0;
            dpos_reg   <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            uuid_reg   <= uuid_next;
            attr_reg   <= attr_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
            dpos_reg   <= dpos_next;
        end
    end

endmodule

/* rtl/core/ncad_out_stage.sv */
// Result register toward the downstream stream.
// Depends on ncad_pkg for the result struct.
module ncad_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           res_valid,
    input  ncad_pkg::res_t res,
    output logic           advance,
    output logic           m_valid,
    input  logic           m_ready,
    output ncad_pkg::res_t m_res
);
    import ncad_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Load when empty or when the held result is being taken.
    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

/* rtl/core/notification_attribute_deframer_core.sv */
// Notification attribute deframer, top level.
// Path: input register, combinational parser, result register, then the output.
// Throughput: one byte per cycle, set by the input and result registers, unless m_tready stalls.
// Reset: synchronous, active-low aresetn clears both stages, disarms parsing,
// returns to the header phase with the attribute id marked invalid.
// Depends on ncad_pkg, ncad_in_stage, ncad_parser, ncad_out_stage.
module notification_attribute_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // request_armed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    input  logic        s_tuser,        // [0] first_of_fragment
    input  logic        s_tlast,        // last_of_fragment
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,        // [31:0] notif_uuid, [39:32] attribute_id,
                                        // [47:40] attr_byte, [63:48] byte_index
    output logic        m_tuser,        // [0] empty_attribute
    output logic        m_tlast         // last_of_attribute
);
    import ncad_pkg::*;

    logic     armed_reg;
    logic     armed_next;
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    res_t     res;
    res_t     m_res;

    assign armed_next = cfg_wr_en ? cfg_wr_data : armed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
        end else begin
            armed_reg <= armed_next;
        end
    end

    assign s_item.data_byte         = s_tdata;
    assign s_item.first_of_fragment = s_tuser;
    assign s_item.last_of_fragment  = s_tlast;

    ncad_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ncad_parser u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .armed     (armed_reg),
        .fire      (item_valid && advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ncad_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.byte_index, m_res.attr_byte, m_res.attribute_id, m_res.notif_uuid};
    assign m_tuser = m_res.empty_attribute;
    assign m_tlast = m_res.last_of_attribute;

    // An empty attribute carries no byte and always closes its attribute.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[63:40] == 24'd0)
        else $error("empty attribute result malformed");

    // Results come only from a held byte while parsing is enabled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> armed_reg && item_valid)
        else $error("result produced while disarmed or without input");

    // Both stages come out of reset empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !item_valid)
        else $error("stage valid after reset");

endmodule

/* sim/ncad_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the notification attribute deframer: tracks accepted bytes and
// register writes, predicts each attribute result and compares it on the result channel.
// Depends on ncad_pkg.
module ncad_checker
    import ncad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          empties_seen
);

    localparam int REPORT_MAX = 10;

    // parser shadow state
    bit          armed;
    phase_t      ph;
    logic [2:0]  hdr_pos;
    logic [31:0] uuid_acc;
    logic [7:0]  attr_id;
    logic [7:0]  len_lo;
    logic [15:0] bytes_left;
    logic [15:0] byte_pos;

    res_t attr_results_due[$];
    int   n_fail;
    int   n_results;
    int   n_empty;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        empties_seen = 0;
        n_fail       = 0;
        n_results    = 0;
        n_empty      = 0;
    end

    function automatic string describe(input res_t r);
        return $sformatf("uuid %h id %h byte %h idx %0d empty %b last %b",
                         r.notif_uuid, r.attribute_id, r.attr_byte, r.byte_index,
                         r.empty_attribute, r.last_of_attribute);
    endfunction

    task automatic clear_parser();
        armed      = 1'b0;
        ph         = PH_HDR;
        hdr_pos    = '0;
        uuid_acc   = '0;
        attr_id    = ATTR_INVALID;
        len_lo     = '0;
        bytes_left = '0;
        byte_pos   = '0;
    endtask

    // Advance the shadow parser by one byte; emits is set when a result is due.
    task automatic parse_byte(input in_item_t it, output bit emits, output res_t r);
        logic [15:0] field_len;
        emits = 1'b0;
        r     = '0;
        if (!armed) return;

        // a fragment opening with command 0 between attributes starts a new response
        if (it.first_of_fragment &&
            (ph == PH_HDR || (ph == PH_ATTRID && it.data_byte == CMD_NEW_HDR))) begin
            ph      = PH_HDR;
            hdr_pos = '0;
        end

        case (ph)
            PH_ATTRID: begin
                attr_id = it.data_byte;
                ph      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_lo = it.data_byte;
                ph     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                field_len = {it.data_byte, len_lo};
                len_lo    = '0;
                byte_pos  = '0;
                if (field_len == 16'd0) begin
                    emits               = 1'b1;
                    r.notif_uuid        = uuid_acc;
                    r.attribute_id      = attr_id;
                    r.empty_attribute   = 1'b1;
                    r.last_of_attribute = 1'b1;
                    bytes_left          = '0;
                    attr_id             = ATTR_INVALID;
                    ph                  = PH_ATTRID;
                end else begin
                    bytes_left = field_len;
                    ph         = PH_DATA;
                end
            end
            PH_DATA: begin
                emits               = 1'b1;
                r.notif_uuid        = uuid_acc;
                r.attribute_id      = attr_id;
                r.attr_byte         = it.data_byte;
                r.byte_index        = byte_pos;
                r.last_of_attribute = (bytes_left <= 16'd1);
                byte_pos            = byte_pos + 16'd1;
                if (bytes_left <= 16'd1) begin
                    bytes_left = '0;
                    attr_id    = ATTR_INVALID;
                    ph         = PH_ATTRID;
                end else begin
                    bytes_left = bytes_left - 16'd1;
                end
            end
            default: begin
                if (hdr_pos == 3'd0)
                    uuid_acc = '0;
                else if (hdr_pos < HDR_LEN)
                    uuid_acc |= 32'(it.data_byte) << (8 * (int'(hdr_pos) - 1));
                hdr_pos = hdr_pos + 3'd1;
                // a fragment end cuts a short header
                if (hdr_pos >= HDR_LEN || it.last_of_fragment) begin
                    hdr_pos = '0;
                    ph      = PH_ATTRID;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        in_item_t req;
        res_t     want;
        res_t     got;
        bit       emits;
        if (!aresetn) begin
            clear_parser();
            attr_results_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                req = '{s_tdata, s_tuser, s_tlast};
                parse_byte(req, emits, want);
                if (emits) attr_results_due.push_back(want);
            end
            if (cfg_wr_en) armed = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                got.notif_uuid        = m_tdata[31:0];
                got.attribute_id      = m_tdata[39:32];
                got.attr_byte         = m_tdata[47:40];
                got.byte_index        = m_tdata[63:48];
                got.empty_attribute   = m_tuser;
                got.last_of_attribute = m_tlast;
                n_results++;
                if (m_tuser) n_empty++;
                if (attr_results_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX)
                        $display("%0t: unexpected result: %s", $realtime, describe(got));
                end else begin
                    want = attr_results_due.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_fail <= REPORT_MAX) begin
                            $display("%0t: result %0d differs", $realtime, n_results);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
            end
        end
        fail_count   <= n_fail;
        pending      <= attr_results_due.size();
        results_seen <= n_results;
        empties_seen <= n_empty;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the notification attribute deframer: drives fragmented
// responses, register writes and result-side stalls; ncad_checker does the checking.
// Depends on ncad_pkg, ncad_checker and the notification_attribute_deframer_core RTL.
module tb_top;
    import ncad_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int IDLE_LIMIT   = 200;
    localparam int DRAIN_CYCLES = 6;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int results_seen;
    int empties_seen;

    int       quiet_cycles = 0;
    int       n_armed      = 0;
    int       n_disarmed   = 0;
    int       n_responses  = 0;
    bit       armed_now    = 1'b0;
    bit       s_steady     = 1'b0;
    bit       m_steady     = 1'b0;
    in_item_t byte_q[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    notification_attribute_deframer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ncad_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .empties_seen (empties_seen)
    );

    // watchdog: any accepted byte, taken result or register write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall before each result unless in a steady stretch
    initial begin
        int stall;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = m_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input in_item_t it);
        int gap;
        gap = s_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.data_byte;
        s_tuser  <= it.first_of_fragment;
        s_tlast  <= it.last_of_fragment;
        do @(posedge aclk); while (!s_tready);
        if (armed_now) n_armed++;
        else n_disarmed++;
    endtask

    task automatic send_noise(input int count);
        in_item_t it;
        repeat (count) begin
            it = '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1))};
            send_byte(it);
        end
    endtask

    // write the arm bit once the block has drained
    task automatic set_armed(input bit value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        armed_now = value;
    endtask

    task automatic disarmed_burst();
        set_armed(1'b0);
        send_noise($urandom_range(3, 10));
        set_armed(1'b1);
    endtask

    task automatic push_raw(input logic [7:0] b, input bit first, input bit last);
        byte_q.push_back('{b, first, last});
    endtask

    // append a byte; opening a fragment closes the previous one
    task automatic add_byte(input logic [7:0] b, input bit opens);
        in_item_t tail;
        if (opens && byte_q.size() > 0) begin
            tail = byte_q.pop_back();
            tail.last_of_fragment = 1'b1;
            byte_q.push_back(tail);
        end
        push_raw(b, opens, 1'b0);
    endtask

    task automatic send_queue(input int pause_at);
        for (int i = 0; i < byte_q.size(); i++) begin
            if (i == pause_at) disarmed_burst();
            send_byte(byte_q[i]);
        end
        byte_q.delete();
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 0;
        if (roll < 85) return $urandom_range(1, 8);
        if (roll < 97) return $urandom_range(9, 40);
        return $urandom_range(200, 300);
    endfunction

    // one well-formed response with random content and fragment boundaries
    task automatic build_response();
        int hdr_bytes;
        int attr_count;
        int data_len;
        bit next_opens;
        in_item_t tail;
        hdr_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : HDR_LEN_INT;
        add_byte(CMD_NEW_HDR, 1'b1);
        for (int i = 1; i < hdr_bytes; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        // a short header must end its fragment
        next_opens = (hdr_bytes < HDR_LEN_INT);
        attr_count = $urandom_range(1, 4);
        repeat (attr_count) begin
            data_len = pick_length();
            add_byte(8'($urandom_range(0, 255)), next_opens || ($urandom_range(0, 5) == 0));
            add_byte(8'(data_len), $urandom_range(0, 5) == 0);
            add_byte(8'(data_len >> 8), $urandom_range(0, 5) == 0);
            next_opens = 1'b0;
            repeat (data_len) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
        tail = byte_q.pop_back();
        tail.last_of_fragment = 1'b1;
        byte_q.push_back(tail);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // disarmed: bytes are dropped
        set_armed(1'b0);
        send_noise(6);
        set_armed(1'b1);

        // full header, empty attribute, two-byte attribute ending in a fresh fragment
        push_raw(8'h00, 1'b1, 1'b0); push_raw(8'hff, 1'b0, 1'b0); push_raw(8'h00, 1'b0, 1'b0);
        push_raw(8'h80, 1'b0, 1'b0); push_raw(8'h01, 1'b0, 1'b0);
        push_raw(8'h00, 1'b0, 1'b0); push_raw(8'h00, 1'b0, 1'b0); push_raw(8'h00, 1'b0, 1'b0);
        push_raw(8'hff, 1'b0, 1'b0); push_raw(8'h02, 1'b0, 1'b0); push_raw(8'h00, 1'b0, 1'b0);
        push_raw(8'hff, 1'b0, 1'b0); push_raw(8'h00, 1'b1, 1'b1);
        // new response with a short header
        push_raw(8'h00, 1'b1, 1'b0); push_raw(8'h12, 1'b0, 1'b1);
        // nonzero id opening a fragment, length split across fragments
        push_raw(8'h07, 1'b1, 1'b0); push_raw(8'h01, 1'b0, 1'b1); push_raw(8'h00, 1'b1, 1'b0);
        push_raw(8'hab, 1'b0, 1'b1);
        // header restarted by a fragment start inside it
        push_raw(8'h00, 1'b1, 1'b0); push_raw(8'h11, 1'b0, 1'b0); push_raw(8'h00, 1'b1, 1'b0);
        push_raw(8'h22, 1'b0, 1'b0); push_raw(8'h33, 1'b0, 1'b0); push_raw(8'h44, 1'b0, 1'b0);
        push_raw(8'h55, 1'b0, 1'b1);
        send_queue(-1);

        while (n_armed < ITEM_TARGET) begin
            s_steady = ($urandom_range(0, 5) == 0);
            m_steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0) begin
                send_noise($urandom_range(1, 2));
            end else begin
                build_response();
                n_responses++;
                send_queue(($urandom_range(0, 11) == 0) ?
                           $urandom_range(0, byte_q.size() - 1) : -1);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes while armed in %0d random responses, %0d while disarmed",
                 n_armed, n_responses, n_disarmed);
        $display("Checked %0d attribute results, %0d of them empty; %0d failures",
                 results_seen, empties_seen, fail_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* notification_attribute_deframer_core.f */
rtl/core/ncad_pkg.sv
rtl/core/ncad_in_stage.sv
rtl/core/ncad_parser.sv
rtl/core/ncad_out_stage.sv
rtl/core/notification_attribute_deframer_core.sv
sim/ncad_checker.sv
sim/tb_top.sv
